>>> rtl/core/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared sizes, types and state codes of the subset sum counter.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Store depth and field widths
  localparam int MAX_ELEMENTS = 20;
  localparam int ELEM_W       = 18;
  localparam int TARGET_W     = 22;
  localparam int COUNT_W      = 20;

  // Derived sizes
  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LOAD_W = $clog2(MAX_ELEMENTS + 1);
  localparam int MASK_W = MAX_ELEMENTS;
  localparam int SUM_W  = ELEM_W + ((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 0) + 1;
  localparam int CMP_W  = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [MASK_W-1:0]  MASK_ONES = {MASK_W{1'b1}};

  // Store write port
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         addr;
    logic signed [ELEM_W-1:0] data;
  } load_t;

  // Start of a count
  typedef struct packed {
    logic              go;
    logic [MASK_W-1:0] last_mask;
    logic              ovf;
  } launch_t;

  // Enumerator control
  typedef enum logic [1:0] {
    ENUM_IDLE,
    ENUM_RUN,
    ENUM_DRAIN
  } enum_state_t;

endpackage

>>> rtl/core/subset_sum_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_sum_counter_core
// Loads up to MAX_ELEMENTS signed elements and, on the last one, counts the
// non-empty subsets whose sum equals the target.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low. The element marked
// last raises busy and starts the count: the enumerator visits the 2^n - 1
// non-empty subsets of n stored elements in Gray-code order, one store read
// per subset, and each step passes through the store read, the running sum
// and compare, and the result register. The result shows on subset_count and
// overflow_flag for one cycle with done high and cannot be held off; busy
// drops in that same cycle, so the next set may start loading at once.
// Elements past the store depth are dropped and flagged. The user must write
// target_sum with target_we only while no count is running; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module subset_sum_counter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ssc_pkg::ELEM_W-1:0]    element_value,
  input  logic                                 last_element,
  input  logic                                 target_we,
  input  logic signed [ssc_pkg::TARGET_W-1:0]  target_sum,
  output logic                                 done,
  output logic [ssc_pkg::COUNT_W-1:0]          subset_count,
  output logic                                 overflow_flag
);

  logic signed [ssc_pkg::TARGET_W-1:0] target;
  logic [ssc_pkg::LOAD_W-1:0]          loaded_count;
  logic [ssc_pkg::LOAD_W-1:0]          n_new;
  logic                                overflow_seen;
  logic                                accept;
  logic                                room;

  ssc_pkg::load_t   load;
  ssc_pkg::launch_t launch;

  // Target register
  always_ff @(posedge clk) begin
    if (rst)            target <= '0;
    else if (target_we) target <= target_sum;
  end

  // Input transfer and store fill
  assign accept = start && !busy;
  assign room   = (loaded_count < ssc_pkg::LOAD_W'(ssc_pkg::MAX_ELEMENTS));
  assign n_new  = room ? loaded_count + ssc_pkg::LOAD_W'(1) : loaded_count;

  assign load.we   = accept && room;
  assign load.addr = loaded_count[ssc_pkg::IDX_W-1:0];
  assign load.data = element_value;

  assign launch.go        = accept && last_element;
  assign launch.last_mask = ssc_pkg::MASK_ONES >>
                            (ssc_pkg::LOAD_W'(ssc_pkg::MAX_ELEMENTS) - n_new);
  assign launch.ovf       = overflow_seen || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (launch.go) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (room) loaded_count  <= n_new;
      else      overflow_seen <= 1'b1;
    end
  end

  // Store and enumerator
  ssc_enum u_enum (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .launch        (launch),
    .target        (target),
    .busy          (busy),
    .done          (done),
    .subset_count  (subset_count),
    .overflow_flag (overflow_flag)
  );

endmodule

>>> rtl/core/ssc_enum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_enum
// Element store and Gray-code subset enumerator. Walks every non-empty
// subset, one store read per subset, keeping a running sum and a hit count.
// ----------------------------------------------------------------------------
module ssc_enum (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ssc_pkg::load_t                          load,
  input  ssc_pkg::launch_t                        launch,
  input  logic signed [ssc_pkg::TARGET_W-1:0]     target,
  output logic                                    busy,
  output logic                                    done,
  output logic [ssc_pkg::COUNT_W-1:0]             subset_count,
  output logic                                    overflow_flag
);

  // Element store, registered read
  logic signed [ssc_pkg::ELEM_W-1:0] mem [ssc_pkg::MAX_ELEMENTS];
  logic signed [ssc_pkg::ELEM_W-1:0] rd_data;

  ssc_pkg::enum_state_t state, state_next;

  logic [ssc_pkg::MASK_W-1:0] step;
  logic [ssc_pkg::MASK_W-1:0] last_mask;
  logic                       ovf;
  logic [ssc_pkg::IDX_W-1:0]  rd_idx;
  logic                       rd_en;
  logic                       step_last;

  logic                       rd_valid;
  logic                       rd_last;
  logic [ssc_pkg::IDX_W-1:0]  rd_idx_q;

  logic [ssc_pkg::MASK_W-1:0]        gray;
  logic signed [ssc_pkg::CMP_W-1:0]  sum;
  logic signed [ssc_pkg::CMP_W-1:0]  elem_ext;
  logic signed [ssc_pkg::CMP_W-1:0]  target_ext;
  logic                              sum_valid;
  logic                              sum_last;

  logic [ssc_pkg::COUNT_W-1:0] count;
  logic [ssc_pkg::COUNT_W-1:0] count_next;
  logic                        hit;

  // Bit toggled by Gray step k is the lowest set bit of k
  always_comb begin
    rd_idx = '0;
    for (int i = ssc_pkg::MASK_W - 1; i >= 0; i--) begin
      if (step[i]) rd_idx = ssc_pkg::IDX_W'(i);
    end
  end

  assign step_last = (step == last_mask);

  // Store write and read
  always_ff @(posedge clk) begin
    if (load.we) mem[load.addr] <= load.data;
    if (rd_en) rd_data <= mem[rd_idx];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) state <= ssc_pkg::ENUM_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    unique case (state)
      ssc_pkg::ENUM_IDLE: begin
        if (launch.go) state_next = ssc_pkg::ENUM_RUN;
      end
      ssc_pkg::ENUM_RUN: begin
        rd_en = 1'b1;
        if (step_last) state_next = ssc_pkg::ENUM_DRAIN;
      end
      ssc_pkg::ENUM_DRAIN: begin
        if (sum_valid && sum_last) state_next = ssc_pkg::ENUM_IDLE;
      end
      default: state_next = ssc_pkg::ENUM_IDLE;
    endcase
  end

  assign busy = (state != ssc_pkg::ENUM_IDLE);

  // Step counter and launch capture
  always_ff @(posedge clk) begin
    if (launch.go && !busy) begin
      step      <= ssc_pkg::MASK_W'(1);
      last_mask <= launch.last_mask;
      ovf       <= launch.ovf;
    end else if (rd_en) begin
      step <= step + ssc_pkg::MASK_W'(1);
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= rd_en;
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= rd_idx;
    rd_last  <= step_last;
  end

  // Running sum stage: add on set, subtract on clear
  assign elem_ext   = ssc_pkg::CMP_W'(rd_data);
  assign target_ext = ssc_pkg::CMP_W'(target);

  always_ff @(posedge clk) begin
    if (rst) sum_valid <= 1'b0;
    else     sum_valid <= rd_valid;
  end

  always_ff @(posedge clk) begin
    if (launch.go && !busy) begin
      gray <= '0;
      sum  <= '0;
    end else if (rd_valid) begin
      gray[rd_idx_q] <= ~gray[rd_idx_q];
      if (gray[rd_idx_q]) sum <= sum - elem_ext;
      else                sum <= sum + elem_ext;
    end
    sum_last <= rd_last;
  end

  // Compare and count stage, saturating
  assign hit = sum_valid && (sum == target_ext);
  assign count_next = (hit && count != ssc_pkg::COUNT_MAX) ?
                      count + ssc_pkg::COUNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (launch.go && !busy) count <= '0;
    else                    count <= count_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= sum_valid && sum_last;
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_last) begin
      subset_count  <= count_next;
      overflow_flag <= ovf;
    end
  end

endmodule
